FILE: src/bqc_pkg.sv
// Shared constants, types and coefficient functions for the band-pass biquad cascade.
package bqc_pkg;

   // Filter structure and fixed-point formats.
   localparam int SECTIONS       = 4;
   localparam int COEF_FRAC_BITS = 30;
   localparam int SAMPLE_W       = 13;
   localparam int OUT_W          = 16;
   localparam int STATE_W        = 48;
   localparam int SIG_FRAC       = 20;
   localparam int COEF_W         = COEF_FRAC_BITS + 2;
   localparam int ROM_FRAC       = 30;
   localparam int ROM_SHIFT      = ROM_FRAC - COEF_FRAC_BITS;
   localparam int MUL_SPLIT      = 16;
   localparam int PROD_W         = STATE_W + COEF_W - COEF_FRAC_BITS;
   localparam int ACC_W          = PROD_W + 2;
   localparam int SEC_W          = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
   localparam int ROM_ROWS       = 8;
   localparam int ROW_W          = 3;
   localparam int COEF_COUNT     = 5;
   localparam int RINT_W         = STATE_W + 1 - SIG_FRAC;

   // Half of one output LSB, used for round-half-up of the final output.
   localparam logic signed [STATE_W:0] ROUND_HALF = (STATE_W + 1)'(64'sd1 <<< (SIG_FRAC - 1));
   // Half of one coefficient LSB when the stored Q2.30 values are narrowed.
   localparam logic signed [63:0] ROM_HALF = (64'sd1 <<< ROM_SHIFT) >>> 1;

   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

   // Coefficient ROM: rows of b0, b1, b2, a1, a2 in Q2.30. Rows four to seven pass through.
   localparam logic signed [63:0] COEF_ROM [ROM_ROWS][COEF_COUNT] = '{
      '{ 64'sd434392, 64'sd868784, 64'sd434392, -64'sd1596367178, 64'sd602507749 },
      '{ 64'sd1073741824, 64'sd2147483648, 64'sd1073741824,
         -64'sd1829843447, 64'sd849832619 },
      '{ 64'sd1073741824, -64'sd2147483648, 64'sd1073741824,
         -64'sd2142445759, 64'sd1068710888 },
      '{ 64'sd1073741824, -64'sd2147483648, 64'sd1073741824,
         -64'sd2145436710, 64'sd1071701694 },
      '{ 64'sd1073741824, 64'sd0, 64'sd0, 64'sd0, 64'sd0 },
      '{ 64'sd1073741824, 64'sd0, 64'sd0, 64'sd0, 64'sd0 },
      '{ 64'sd1073741824, 64'sd0, 64'sd0, 64'sd0, 64'sd0 },
      '{ 64'sd1073741824, 64'sd0, 64'sd0, 64'sd0, 64'sd0 }
   };

   typedef enum logic [2:0] {
      COEF_B0,
      COEF_B1,
      COEF_B2,
      COEF_A1,
      COEF_A2
   } coef_sel_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   // Steps of one section: three b products issued, then the output, then the a products.
   typedef enum logic [3:0] {
      STEP_B0,
      STEP_B1,
      STEP_B2,
      STEP_OUT,
      STEP_A1,
      STEP_A2,
      STEP_GAP,
      STEP_N1,
      STEP_N2
   } step_type;

   typedef struct packed {
      logic             idle;
      logic             run;
      logic             done;
      step_type         step;
      logic [SEC_W-1:0] sec;
   } ctrl_type;

   // Coefficient of one row in Q2.F, rounded half up and saturated to the Q2.F range.
   function automatic logic signed [COEF_W-1:0] coef_at(input logic [ROW_W-1:0] row,
                                                        input coef_sel_type sel);
      logic signed [63:0] c;
      logic signed [63:0] hi;
      c  = COEF_ROM[row][sel];
      hi = (64'sd1 <<< (COEF_W - 1)) - 64'sd1;
      c  = (c + ROM_HALF) >>> ROM_SHIFT;
      if (c > hi) begin
         c = hi;
      end
      if (c < -hi - 64'sd1) begin
         c = -hi - 64'sd1;
      end
      return c[COEF_W-1:0];
   endfunction

   // Saturates a wide sum to the signed state range.
   function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
      logic [STATE_W-1:0] res;
      if (v[ACC_W-1:STATE_W-1] == '0 || v[ACC_W-1:STATE_W-1] == '1) begin
         res = v[STATE_W-1:0];
      end else if (v[ACC_W-1]) begin
         res = {1'b1, {(STATE_W - 1){1'b0}}};
      end else begin
         res = {1'b0, {(STATE_W - 1){1'b1}}};
      end
      return res;
   endfunction

endpackage

FILE: src/bqc_if.sv
// Request and response channel interfaces of the biquad cascade.
interface bqc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [bqc_pkg::SAMPLE_W-1:0] sample;
   logic                                restart;

   modport source (output valid, output sample, output restart, input ready);
   modport sink (input valid, input sample, input restart, output ready);
endinterface

interface bqc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [bqc_pkg::OUT_W-1:0] filtered;
   logic                             saturated;

   modport source (output valid, output filtered, output saturated, input ready);
   modport sink (input valid, input filtered, input saturated, output ready);
endinterface

FILE: src/bqc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bqc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [WIDTH-1:0]     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: src/bqc_mul.sv
// Three-stage pipelined multiplier giving floor(signal * coefficient / 2^F).
module bqc_mul (
   input  logic                                 clock,
   input  logic signed [bqc_pkg::STATE_W-1:0]   operand,
   input  logic signed [bqc_pkg::COEF_W-1:0]    coef,
   output logic signed [bqc_pkg::PROD_W-1:0]    product
);
   localparam int AH_W  = bqc_pkg::STATE_W - bqc_pkg::MUL_SPLIT;
   localparam int HI_W  = AH_W + bqc_pkg::COEF_W;
   localparam int LO_W  = bqc_pkg::MUL_SPLIT + 1 + bqc_pkg::COEF_W;
   localparam int SUM_W = HI_W + 1;
   localparam int FIN_SHIFT = bqc_pkg::COEF_FRAC_BITS - bqc_pkg::MUL_SPLIT;

   logic signed [AH_W-1:0]                 op_hi;
   logic signed [HI_W-1:0]                 hi_in;
   logic signed [HI_W-1:0]                 hi_ff;
   logic signed [HI_W-1:0]                 hi2_ff;
   logic [bqc_pkg::MUL_SPLIT-1:0]          lo_op_ff;
   logic signed [bqc_pkg::COEF_W-1:0]      coef_ff;
   logic signed [bqc_pkg::MUL_SPLIT:0]     lo_op_ext;
   logic signed [LO_W-1:0]                 lo_in;
   logic signed [LO_W-1:0]                 lo_ff;
   logic signed [LO_W-1:0]                 lo_shift;
   logic signed [SUM_W-1:0]                sum_full;
   logic signed [SUM_W-1:0]                sum_shift;
   logic signed [bqc_pkg::PROD_W-1:0]      product_in;
   logic signed [bqc_pkg::PROD_W-1:0]      product_ff;

   // Stage one: upper part of the signal times the coefficient.
   always_comb begin
      op_hi = operand[bqc_pkg::STATE_W-1:bqc_pkg::MUL_SPLIT];
      hi_in = op_hi * coef;
   end

   // Stage two: unsigned lower part of the signal times the coefficient.
   always_comb begin
      lo_op_ext = {1'b0, lo_op_ff};
      lo_in     = lo_op_ext * coef_ff;
   end

   // Stage three: combine both partial products with floor truncation.
   always_comb begin
      lo_shift   = lo_ff >>> bqc_pkg::MUL_SPLIT;
      sum_full   = {{(SUM_W - HI_W){hi2_ff[HI_W-1]}}, hi2_ff}
                 + {{(SUM_W - LO_W){lo_shift[LO_W-1]}}, lo_shift};
      sum_shift  = sum_full >>> FIN_SHIFT;
      product_in = sum_shift[bqc_pkg::PROD_W-1:0];
   end

   always_ff @(posedge clock) begin
      hi_ff      <= hi_in;
      lo_op_ff   <= operand[bqc_pkg::MUL_SPLIT-1:0];
      coef_ff    <= coef;
      hi2_ff     <= hi_ff;
      lo_ff      <= lo_in;
      product_ff <= product_in;
   end

   assign product = product_ff;
endmodule

FILE: src/bqc_seq.sv
// Sequencer: item state machine plus the step and section counters.
module bqc_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                out_free,
   output bqc_pkg::ctrl_type   ctrl
);
   bqc_pkg::state_type            state_ff;
   bqc_pkg::state_type            state_in;
   bqc_pkg::step_type             step_ff;
   bqc_pkg::step_type             step_in;
   logic [bqc_pkg::SEC_W-1:0]     sec_ff;
   logic [bqc_pkg::SEC_W-1:0]     sec_in;
   logic                          last_sec;
   logic                          last_step;

   assign last_sec  = (sec_ff == bqc_pkg::SEC_W'(bqc_pkg::SECTIONS - 1));
   assign last_step = (step_ff == bqc_pkg::STEP_N2);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bqc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = bqc_pkg::ST_RUN;
            end
         end
         bqc_pkg::ST_RUN: begin
            if (last_step && last_sec) begin
               state_in = bqc_pkg::ST_DONE;
            end
         end
         bqc_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = bqc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bqc_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      ctrl.idle     = 1'b0;
      ctrl.run      = 1'b0;
      ctrl.done     = 1'b0;
      ctrl.step     = step_ff;
      ctrl.sec      = sec_ff;
      unique case (state_ff)
         bqc_pkg::ST_IDLE: ctrl.idle = 1'b1;
         bqc_pkg::ST_RUN:  ctrl.run  = 1'b1;
         bqc_pkg::ST_DONE: ctrl.done = 1'b1;
         default:          ctrl.idle = 1'b0;
      endcase
   end

   // Step and section counters: nine steps per section, sections in order.
   always_comb begin
      step_in = step_ff;
      sec_in  = sec_ff;
      if (accept) begin
         step_in = bqc_pkg::STEP_B0;
         sec_in  = '0;
      end else if (state_ff == bqc_pkg::ST_RUN) begin
         if (last_step) begin
            step_in = bqc_pkg::STEP_B0;
            if (!last_sec) begin
               sec_in = sec_ff + 1'b1;
            end
         end else begin
            step_in = bqc_pkg::step_type'(step_ff + 4'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bqc_pkg::ST_IDLE;
         step_ff  <= bqc_pkg::STEP_B0;
         sec_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         sec_ff   <= sec_in;
      end
   end
endmodule

FILE: src/biquad_cascade_bandpass_filter_unit.sv
// Top level of the band-pass biquad cascade: state RAM, shared multiplier and datapath.
// Each section runs one RAM read, five products through the shared three-stage
// multiplier and one write-back. Items are taken one at a time: a new request is
// accepted in the cycle after the result is loaded into the output register, which
// can wait while a previous result has not yet been taken.
// Reset clears the control state and the section valid bits, so all states read as zero.
module biquad_cascade_bandpass_filter_unit (
   input  logic        clock,
   input  logic        reset,
   bqc_req_if.sink     req_ch,
   bqc_rsp_if.source   rsp_ch
);
   localparam int STATE_W = bqc_pkg::STATE_W;
   localparam int PROD_W  = bqc_pkg::PROD_W;
   localparam int ACC_W   = bqc_pkg::ACC_W;
   localparam int OUT_W   = bqc_pkg::OUT_W;
   localparam int RINT_W  = bqc_pkg::RINT_W;
   localparam int SAMPLE_W = bqc_pkg::SAMPLE_W;
   localparam int SIG_FRAC = bqc_pkg::SIG_FRAC;

   bqc_pkg::ctrl_type                  ctrl;
   logic                               accept;
   logic                               out_free;
   logic                               load_out;

   logic [bqc_pkg::SECTIONS-1:0]       valid_ff;
   logic [bqc_pkg::SECTIONS-1:0]       valid_in;

   logic signed [STATE_W-1:0]          y_ff;
   logic signed [STATE_W-1:0]          y_in;
   logic signed [STATE_W-1:0]          o_ff;
   logic signed [STATE_W-1:0]          o_in;
   logic signed [STATE_W-1:0]          fd_ff;
   logic signed [STATE_W-1:0]          fd_in;
   logic signed [STATE_W-1:0]          sd_ff;
   logic signed [STATE_W-1:0]          sd_in;
   logic signed [ACC_W-1:0]            acc1_ff;
   logic signed [ACC_W-1:0]            acc1_in;
   logic signed [ACC_W-1:0]            acc2_ff;
   logic signed [ACC_W-1:0]            acc2_in;
   logic signed [STATE_W-1:0]          n1_ff;
   logic signed [STATE_W-1:0]          n1_in;
   logic signed [STATE_W-1:0]          n2_new;

   logic signed [STATE_W-1:0]          mul_operand;
   logic signed [bqc_pkg::COEF_W-1:0]  mul_coef;
   logic signed [PROD_W-1:0]           mul_product;
   bqc_pkg::coef_sel_type              coef_sel;

   logic                               ram_we;
   logic                               ram_re;
   logic [2*STATE_W-1:0]               ram_rd_data;

   logic signed [ACC_W-1:0]            prod_ext;
   logic signed [ACC_W-1:0]            fd_ext;
   logic signed [ACC_W-1:0]            sd_ext;

   logic signed [STATE_W:0]            rnd_sum;
   logic signed [RINT_W-1:0]           rnd_int;
   logic signed [OUT_W-1:0]            filtered_in;
   logic                               saturated_in;
   logic signed [OUT_W-1:0]            filtered_ff;
   logic                               saturated_ff;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign load_out = ctrl.done && out_free;
   assign req_ch.ready = ctrl.idle;

   bqc_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .out_free (out_free),
      .ctrl     (ctrl)
   );

   // Section state RAM: first delay in the upper half, second delay in the lower half.
   assign ram_re = ctrl.run && (ctrl.step == bqc_pkg::STEP_B0);
   assign ram_we = ctrl.run && (ctrl.step == bqc_pkg::STEP_N2);

   bqc_ram #(
      .WIDTH (2 * STATE_W),
      .DEPTH (bqc_pkg::SECTIONS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ctrl.sec),
      .wr_data ({n1_ff, n2_new}),
      .rd_en   (ram_re),
      .rd_addr (ctrl.sec),
      .rd_data (ram_rd_data)
   );

   // Multiplier operand selection: b products use the section input, a products its output.
   always_comb begin
      mul_operand = y_ff;
      coef_sel    = bqc_pkg::COEF_B0;
      case (ctrl.step)
         bqc_pkg::STEP_B1: coef_sel = bqc_pkg::COEF_B1;
         bqc_pkg::STEP_B2: coef_sel = bqc_pkg::COEF_B2;
         bqc_pkg::STEP_A1: begin
            mul_operand = o_ff;
            coef_sel    = bqc_pkg::COEF_A1;
         end
         bqc_pkg::STEP_A2: begin
            mul_operand = o_ff;
            coef_sel    = bqc_pkg::COEF_A2;
         end
         default: coef_sel = bqc_pkg::COEF_B0;
      endcase
      mul_coef = bqc_pkg::coef_at(bqc_pkg::ROW_W'(ctrl.sec), coef_sel);
   end

   bqc_mul u_mul (
      .clock   (clock),
      .operand (mul_operand),
      .coef    (mul_coef),
      .product (mul_product)
   );

   // Section arithmetic on the products as they leave the multiplier.
   always_comb begin
      prod_ext = {{(ACC_W - PROD_W){mul_product[PROD_W-1]}}, mul_product};
      fd_ext   = {{(ACC_W - STATE_W){fd_ff[STATE_W-1]}}, fd_ff};
      sd_ext   = {{(ACC_W - STATE_W){sd_ff[STATE_W-1]}}, sd_ff};
      fd_in    = valid_ff[ctrl.sec] ? ram_rd_data[2*STATE_W-1:STATE_W] : '0;
      sd_in    = valid_ff[ctrl.sec] ? ram_rd_data[STATE_W-1:0] : '0;
      o_in     = bqc_pkg::sat_state(prod_ext + fd_ext);
      acc1_in  = prod_ext + sd_ext;
      acc2_in  = prod_ext;
      n1_in    = bqc_pkg::sat_state(acc1_ff - prod_ext);
      n2_new   = bqc_pkg::sat_state(acc2_ff - prod_ext);
      if (accept) begin
         y_in = {{(STATE_W - SAMPLE_W - SIG_FRAC){req_ch.sample[SAMPLE_W-1]}},
                 req_ch.sample, {SIG_FRAC{1'b0}}};
      end else if (ram_we) begin
         y_in = o_ff;
      end else begin
         y_in = y_ff;
      end
   end

   always_ff @(posedge clock) begin
      y_ff <= y_in;
      if (ctrl.run) begin
         case (ctrl.step)
            bqc_pkg::STEP_B1: begin
               fd_ff <= fd_in;
               sd_ff <= sd_in;
            end
            bqc_pkg::STEP_OUT: o_ff    <= o_in;
            bqc_pkg::STEP_A1:  acc1_ff <= acc1_in;
            bqc_pkg::STEP_A2:  acc2_ff <= acc2_in;
            bqc_pkg::STEP_N1:  n1_ff   <= n1_in;
            default: begin
            end
         endcase
      end
   end

   // Valid bits: a restart clears every section, a write-back marks its section.
   always_comb begin
      valid_in = valid_ff;
      if (accept && req_ch.restart) begin
         valid_in = '0;
      end else if (ram_we) begin
         valid_in[ctrl.sec] = 1'b1;
      end
   end

   // Output rounding half up and saturation to the 16-bit range.
   always_comb begin
      rnd_sum = {y_ff[STATE_W-1], y_ff} + bqc_pkg::ROUND_HALF;
      rnd_int = rnd_sum[STATE_W:SIG_FRAC];
      if (rnd_int[RINT_W-1:OUT_W-1] == '0 || rnd_int[RINT_W-1:OUT_W-1] == '1) begin
         filtered_in  = rnd_int[OUT_W-1:0];
         saturated_in = 1'b0;
      end else if (rnd_int[RINT_W-1]) begin
         filtered_in  = bqc_pkg::OUT_MIN;
         saturated_in = 1'b1;
      end else begin
         filtered_in  = bqc_pkg::OUT_MAX;
         saturated_in = 1'b1;
      end
   end

   // Output register: it holds a finished result until its transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         filtered_ff  <= filtered_in;
         saturated_ff <= saturated_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.filtered  = filtered_ff;
   assign rsp_ch.saturated = saturated_ff;

   // A transfer starts the first section at its first step.
   a_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (ctrl.run && ctrl.step == bqc_pkg::STEP_B0 && ctrl.sec == '0))
      else $error("item did not start at the first section");

   // A restart leaves every section state reading as zero.
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.restart) |=> (valid_ff == '0))
      else $error("restart did not clear the section states");

   // A write-back marks its own section as holding state.
   a_writeback_valid: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> valid_ff[$past(ctrl.sec)])
      else $error("written section not marked valid");

   // A clipped result sits at one of the range limits.
   a_sat_limits: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.saturated) |->
         (rsp_ch.filtered == bqc_pkg::OUT_MAX || rsp_ch.filtered == bqc_pkg::OUT_MIN))
      else $error("saturation flag set on an unclipped value");
endmodule
